@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked at every clock edge outside reset
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// implication whose consequent is checked in the cycle after the antecedent
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

@@ rtl/gcc_pkg.sv @@
// shared types and constants for the greedy clique cover block
`default_nettype none
package gcc_pkg;
  localparam int NumVertices = 4096;
  localparam int MaxDegree   = 256;
  localparam int VtxW   = $clog2(NumVertices);
  localparam int CliqW  = $clog2(NumVertices + 1);
  localparam int FillW  = $clog2(MaxDegree + 1);
  localparam int BufAw  = (MaxDegree > 1) ? $clog2(MaxDegree) : 1;
  localparam int QDepth = 2;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeNbr   = 2'd1;
  localparam logic [1:0] ModeEnd   = 2'd2;

  typedef struct packed {
    logic [1:0]      mode;
    logic [VtxW-1:0] vertex;
    logic [VtxW-1:0] neighbor;
  } word_t;
endpackage
`default_nettype wire

@@ rtl/gcc_queue.sv @@
// two-entry queue between the front and back parts
`default_nettype none
module gcc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  gcc_pkg::word_t     in_word,
  output logic               out_valid,
  input  wire logic          out_ready,
  output gcc_pkg::word_t     out_word
);
  import gcc_pkg::*;
  word_t mem [QDepth];
  logic [$clog2(QDepth)-1:0] wp, rp;
  logic [$clog2(QDepth+1)-1:0] cnt;
  logic push, pop;

  assign in_ready  = (cnt != QDepth[$clog2(QDepth+1)-1:0]);
  assign out_valid = (cnt != '0);
  assign out_word  = mem[rp];
  assign push = in_valid & in_ready;
  assign pop  = out_valid & out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= in_word;
    if (rst) begin
      wp <= '0; rp <= '0; cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + {{($clog2(QDepth+1)-1){1'b0}}, push}
                 - {{($clog2(QDepth+1)-1){1'b0}}, pop};
    end
  end
endmodule
`default_nettype wire

@@ rtl/gcc_engine.sv @@
// back part: clearing sweep, clique lookup, tally update, end-of-vertex walk and placement
`default_nettype none
module gcc_engine (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  gcc_pkg::word_t            in_word,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [gcc_pkg::VtxW-1:0]  placed_vertex,
  output logic [gcc_pkg::CliqW-1:0] clique_id,
  output logic                      opened_new,
  output logic [gcc_pkg::CliqW-1:0] clique_count,
  output logic                      neighbors_dropped
);
  import gcc_pkg::*;

  typedef enum logic [3:0] {
    S_SWEEP, S_IDLE, S_NLOOK, S_NCAP, S_NTALLY, S_NWRITE,
    S_WBUF, S_WFETCH, S_WLOOK, S_WREAD, S_WWAIT, S_WEVAL, S_PLACE, S_FINAL
  } state_t;

  // memories; a sweep zeroes clique numbers and tallies after reset and on clear
  logic [CliqW-1:0] cov_mem [NumVertices];
  logic [CliqW-1:0] mem_mem [NumVertices+1];
  logic [CliqW-1:0] tal_mem [NumVertices+1];
  logic [VtxW-1:0]  buf_mem [MaxDegree];

  state_t state;
  logic [CliqW-1:0] sweep;
  logic [FillW-1:0] fill, idx;
  logic ovf;
  logic [CliqW-1:0] opened, best, best_cnt, cur_c;
  logic [VtxW-1:0] vtx, nb, buf_rd;
  logic [CliqW-1:0] cov_rd, tal_rd, mem_rd;
  logic nb_oor;
  logic [CliqW-1:0] chosen;
  logic is_new;

  assign in_ready = (state == S_IDLE);

  wire logic [CliqW-1:0] look_c = nb_oor ? '0 : cov_rd;

  // placement choice from the walk result
  always_comb begin
    if (best != '0) begin
      chosen = best; is_new = 1'b0;
    end else if (opened < CliqW'(NumVertices)) begin
      chosen = opened + 1'b1; is_new = 1'b1;
    end else begin
      chosen = '0; is_new = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cov_rd <= cov_mem[nb];
    tal_rd <= tal_mem[cur_c];
    mem_rd <= mem_mem[cur_c];
    buf_rd <= buf_mem[idx[BufAw-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_SWEEP; sweep <= '0; fill <= '0; ovf <= 1'b0;
      opened <= '0; out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_SWEEP: begin
          // zero the tally memory and clique numbers
          tal_mem[sweep] <= '0;
          if (sweep < CliqW'(NumVertices)) cov_mem[sweep[VtxW-1:0]] <= '0;
          sweep <= sweep + 1'b1;
          if (sweep == CliqW'(NumVertices)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          case (in_word.mode)
            ModeClear: begin
              fill <= '0; ovf <= 1'b0; opened <= '0;
              sweep <= '0; state <= S_SWEEP;
            end
            ModeNbr: begin
              if (fill < FillW'(MaxDegree)) begin
                buf_mem[fill[BufAw-1:0]] <= in_word.neighbor;
                fill <= fill + 1'b1;
                nb <= in_word.neighbor;
                nb_oor <= ({1'b0, in_word.neighbor} >= (VtxW+1)'(NumVertices));
                state <= S_NLOOK;
              end else ovf <= 1'b1;
            end
            ModeEnd: begin
              vtx <= in_word.vertex; idx <= '0; best <= '0; best_cnt <= '0;
              state <= S_WBUF;
            end
            default: ;
          endcase
        end
        S_NLOOK: state <= S_NCAP;
        S_NCAP: begin cur_c <= look_c; state <= S_NTALLY; end
        S_NTALLY: state <= S_NWRITE;
        S_NWRITE: begin tal_mem[cur_c] <= tal_rd + 1'b1; state <= S_IDLE; end
        S_WBUF: begin
          if (idx == fill) begin
            cur_c <= best;
            state <= S_PLACE;
          end else state <= S_WFETCH;
        end
        S_WFETCH: begin
          nb <= buf_rd;
          nb_oor <= ({1'b0, buf_rd} >= (VtxW+1)'(NumVertices));
          state <= S_WLOOK;
        end
        S_WLOOK: state <= S_WREAD;
        S_WREAD: begin cur_c <= look_c; state <= S_WWAIT; end
        S_WWAIT: state <= S_WEVAL;
        S_WEVAL: begin
          // tally and member count of this clique now sit in tal_rd / mem_rd
          if (cur_c != '0 && tal_rd == mem_rd && tal_rd > best_cnt) begin
            best <= cur_c; best_cnt <= tal_rd;
          end
          tal_mem[cur_c] <= '0;
          idx <= idx + 1'b1;
          state <= S_WBUF;
        end
        S_PLACE: state <= S_FINAL;
        S_FINAL: if (!out_valid) begin
          if (best != '0) mem_mem[best] <= mem_rd + 1'b1;
          else if (is_new) begin
            mem_mem[chosen] <= CliqW'(1);
            opened <= chosen;
          end
          cov_mem[vtx] <= chosen;
          placed_vertex <= vtx;
          clique_id <= chosen;
          opened_new <= is_new;
          clique_count <= is_new ? chosen : opened;
          neighbors_dropped <= ovf;
          out_valid <= 1'b1;
          fill <= '0; ovf <= 1'b0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/greedy_clique_cover.sv @@
// greedy clique cover: front queue plus placement engine
// neighbor word: the engine takes it, looks up its clique, reads the tally and writes it back
// end word: the engine walks every buffered neighbor, then places the vertex, later while an earlier result still waits
// clear word: the engine sweeps every clique number and tally to zero
// the two-word queue registers words before the engine and holds them while it works
// reset: synchronous, then a sweep clears clique numbers and tallies
`default_nettype none
module greedy_clique_cover (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  mode,
  input  wire logic [11:0] vertex,
  input  wire logic [11:0] neighbor,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [11:0]      placed_vertex,
  output logic [12:0]      clique_id,
  output logic             opened_new,
  output logic [12:0]      clique_count,
  output logic             neighbors_dropped
);
  import gcc_pkg::*;
  word_t in_word, q_word;
  logic q_valid, q_ready;

  // pack the input word for the queue
  assign in_word = '{mode: mode, vertex: vertex, neighbor: neighbor};

  gcc_queue u_queue (
    .clk, .rst, .in_valid, .in_ready, .in_word,
    .out_valid(q_valid), .out_ready(q_ready), .out_word(q_word)
  );

  gcc_engine u_engine (
    .clk, .rst, .in_valid(q_valid), .in_ready(q_ready), .in_word(q_word),
    .out_valid, .out_ready, .placed_vertex, .clique_id, .opened_new,
    .clique_count, .neighbors_dropped
  );
endmodule
`default_nettype wire

@@ rtl/gcc_checker.sv @@
// port-level checker for the greedy clique cover, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module gcc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [12:0] clique_id,
  input wire logic        opened_new,
  input wire logic [12:0] clique_count
);
  `CHK_IMPLY(a_new_is_last, clk, rst, out_valid && opened_new, clique_id == clique_count, "new clique id")
  `CHK_IMPLY(a_new_nonzero, clk, rst, out_valid && opened_new, clique_id != 13'd0, "zero new clique")
  `CHK_IMPLY(a_id_range, clk, rst, out_valid, clique_id <= clique_count, "id beyond count")
  `CHK_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(clique_id), "result dropped")
endmodule
bind greedy_clique_cover gcc_checker u_chk (.*);
`default_nettype wire
